// ===== rtl/core/upsw_pkg.sv =====
// Shared types and constants for the up/down stopwatch counter.
package upsw_pkg;

    localparam int unsigned MS_PER_SEC   = 1000;
    localparam int unsigned SEC_PER_MIN  = 60;
    localparam int unsigned MIN_PER_HOUR = 60;
    localparam int unsigned HOUR_WRAP    = 99;
    localparam int unsigned STEP_MAX     = 999;

    localparam int unsigned HOUR_W   = 7;
    localparam int unsigned MIN_W    = 6;
    localparam int unsigned SEC_W    = 6;
    localparam int unsigned MS_W     = 10;
    localparam int unsigned BLINK_W  = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_RELOAD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_THRESHOLD = 2'd2;

    localparam logic [MS_W-1:0]    STEP_RESET      = 10'd150;
    localparam logic [BLINK_W-1:0] RELOAD_RESET    = 8'd15;
    localparam logic [BLINK_W-1:0] THRESHOLD_RESET = 8'd2;

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 32;

    typedef struct packed {
        logic [HOUR_W-1:0] hours;
        logic [MIN_W-1:0]  minutes;
        logic [SEC_W-1:0]  seconds;
        logic [MS_W-1:0]   millis;
    } time_t;

    typedef struct packed {
        logic bump_hours;
        logic bump_minutes;
        logic bump_seconds;
        logic count_down;
        logic count_up;
        logic clear_time;
    } tick_flags_t;

endpackage

// ===== rtl/core/upsw_time_calc.sv =====
// Next-state logic for one tick: blink counter and carry/borrow time update.
module upsw_time_calc
    import upsw_pkg::*;
(
    input  time_t                cur_time,
    input  logic [BLINK_W-1:0]   cur_blink,
    input  tick_flags_t          flags,
    input  logic [MS_W-1:0]      step_ms,
    input  logic [BLINK_W-1:0]   blink_reload,
    input  logic [BLINK_W-1:0]   blink_threshold,
    output time_t                next_time,
    output logic [BLINK_W-1:0]   next_blink,
    output logic                 visible,
    output logic                 timeout
);

    localparam logic [HOUR_W-1:0] HOUR_LAST = HOUR_W'(HOUR_WRAP - 1);
    localparam logic [MIN_W-1:0]  MIN_LAST  = MIN_W'(MIN_PER_HOUR - 1);
    localparam logic [SEC_W-1:0]  SEC_LAST  = SEC_W'(SEC_PER_MIN - 1);
    localparam logic [MS_W:0]     MS_WRAP   = (MS_W+1)'(MS_PER_SEC);

    function automatic time_t add_hour(time_t t);
        time_t r;
        r = t;
        if (t.hours >= HOUR_LAST) r.hours = '0;
        else                      r.hours = t.hours + 1'b1;
        return r;
    endfunction

    function automatic time_t add_minute(time_t t);
        time_t r;
        r = t;
        if (t.minutes >= MIN_LAST) begin
            r.minutes = '0;
            r = add_hour(r);
        end else begin
            r.minutes = t.minutes + 1'b1;
        end
        return r;
    endfunction

    function automatic time_t add_second(time_t t);
        time_t r;
        r = t;
        if (t.seconds >= SEC_LAST) begin
            r.seconds = '0;
            r = add_minute(r);
        end else begin
            r.seconds = t.seconds + 1'b1;
        end
        return r;
    endfunction

    logic [MS_W:0] ms_sum;
    time_t         t;

    // blink counter runs on every tick regardless of flags
    always_comb begin
        if (cur_blink != '0) next_blink = cur_blink - 1'b1;
        else                 next_blink = blink_reload;
        visible = (next_blink > blink_threshold);
    end

    always_comb begin
        t       = cur_time;
        timeout = 1'b0;
        ms_sum  = '0;

        if (flags.clear_time) t = '0;

        if (flags.count_up) begin
            ms_sum = {1'b0, t.millis} + {1'b0, step_ms};
            if (ms_sum >= MS_WRAP) begin
                t.millis = MS_W'(ms_sum - MS_WRAP);
                t = add_second(t);
            end else begin
                t.millis = ms_sum[MS_W-1:0];
            end
        end

        if (flags.count_down) begin
            if (t.millis < step_ms) begin
                t.millis = MS_W'(MS_WRAP + {1'b0, t.millis} - {1'b0, step_ms});
                if (t.seconds != '0) begin
                    t.seconds = t.seconds - 1'b1;
                end else begin
                    t.seconds = SEC_LAST;
                    if (t.minutes != '0) begin
                        t.minutes = t.minutes - 1'b1;
                    end else begin
                        t.minutes = MIN_LAST;
                        if (t.hours != '0) begin
                            t.hours = t.hours - 1'b1;
                        end else begin
                            // underflow past zero: clear and flag
                            t       = '0;
                            timeout = 1'b1;
                        end
                    end
                end
            end else begin
                t.millis = t.millis - step_ms;
            end
        end

        if (flags.bump_seconds) t = add_second(t);
        if (flags.bump_minutes) t = add_minute(t);
        if (flags.bump_hours)   t = add_hour(t);

        next_time = t;
    end

endmodule

// ===== rtl/core/up_down_stopwatch_counter_unit.sv =====
// Up/down stopwatch counter: top level with stream ports and configuration.
// Path: a tick transaction goes through the input register, then through the
//   time/blink update into the result register, which holds it while m_ stalls.
// Throughput: one tick per cycle while m_ is not stalled; the counter state is updated
//   once per accepted tick, so ticks may arrive back to back.
// Reset (aresetn low, synchronous): time and blink counter clear, both stages empty,
//   registers return to step 150 ms, blink reload 15, blink threshold 2.
module up_down_stopwatch_counter_unit
    import upsw_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    // configuration write port
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,

    // tick input
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [0] clear_time, [1] count_up, [2] count_down, [3] bump_seconds,
    // [4] bump_minutes, [5] bump_hours, [7:6] zero
    input  logic [S_TDATA_W-1:0]    s_tdata,

    // result output
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [6:0] hours_now, [12:7] minutes_now, [18:13] seconds_now,
    // [28:19] millis_now, [29] digit_visible, [30] timeout_pulse, [31] zero
    output logic [M_TDATA_W-1:0]    m_tdata
);

    // ---------------------------------------------------------------
    // Configuration registers. The step is clamped to 999 on write so
    // one carry or borrow always covers a count tick.
    // ---------------------------------------------------------------
    logic [MS_W-1:0]    step_reg;
    logic [BLINK_W-1:0] reload_reg;
    logic [BLINK_W-1:0] threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= STEP_RESET;
            reload_reg    <= RELOAD_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TICK_STEP: begin
                    step_reg <= (cfg_wdata > MS_W'(STEP_MAX)) ? MS_W'(STEP_MAX)
                                                              : cfg_wdata;
                end
                REG_BLINK_RELOAD:    reload_reg    <= cfg_wdata[BLINK_W-1:0];
                REG_BLINK_THRESHOLD: threshold_reg <= cfg_wdata[BLINK_W-1:0];
                default: ;  // unused index: write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: input stage advances into the result register when
    // the result register is empty or being drained this cycle.
    // ---------------------------------------------------------------
    logic        in_valid_reg;
    tick_flags_t in_flags_reg;
    logic        out_valid_reg;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_flags_reg <= tick_flags_t'(s_tdata[5:0]);
        end
    end

    // ---------------------------------------------------------------
    // Counter state and next-state logic
    // ---------------------------------------------------------------
    time_t              time_reg;
    logic [BLINK_W-1:0] blink_reg;
    time_t              time_next;
    logic [BLINK_W-1:0] blink_next;
    logic               visible_next;
    logic               timeout_next;

    upsw_time_calc u_calc (
        .cur_time        (time_reg),
        .cur_blink       (blink_reg),
        .flags           (in_flags_reg),
        .step_ms         (step_reg),
        .blink_reload    (reload_reg),
        .blink_threshold (threshold_reg),
        .next_time       (time_next),
        .next_blink      (blink_next),
        .visible         (visible_next),
        .timeout         (timeout_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg  <= '0;
            blink_reg <= '0;
        end else if (advance) begin
            time_reg  <= time_next;
            blink_reg <= blink_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    time_t res_time_reg;
    logic  res_visible_reg;
    logic  res_timeout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_time_reg    <= time_next;
            res_visible_reg <= visible_next;
            res_timeout_reg <= timeout_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_timeout_reg, res_visible_reg,
                       res_time_reg.millis, res_time_reg.seconds,
                       res_time_reg.minutes, res_time_reg.hours};

endmodule

// ===== rtl/core/upsw_checker.sv =====
// Port-level checks for the stopwatch counter, bound to the top level.
module upsw_checker
    import upsw_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    // timeout clears the time; later bumps only touch seconds and up, so ms stay zero
    a_timeout_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[30]) |-> (m_tdata[28:19] == '0))
        else $error("timeout result with nonzero milliseconds");

    // every shown time stays inside its unit range
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] < 7'(HOUR_WRAP)) && (m_tdata[12:7] < 6'(MIN_PER_HOUR))
                  && (m_tdata[18:13] < 6'(SEC_PER_MIN))
                  && (m_tdata[28:19] < 10'(MS_PER_SEC)) && !m_tdata[31])
        else $error("time field out of range");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped or changed under stall");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind up_down_stopwatch_counter_unit upsw_checker u_upsw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
